// File: sv/fbrf_pkg.sv
// Package for the page frame buffer rectangle fill core.
// Holds the operation codes, the sequencer state type and the result struct.
// No dependencies.
`default_nettype none

package fbrf_pkg;

    typedef enum logic [1:0] {
        OP_SET  = 2'd0,
        OP_RECT = 2'd1,
        OP_FILL = 2'd2,
        OP_READ = 2'd3
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FILL  = 5'b00010,
        S_RECT  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_RES   = 5'b10000
    } t_state;

    typedef struct packed {
        logic load;
        logic zero;
    } t_res;

    localparam logic [7:0] BYTE_ALL  = 8'hFF;
    localparam logic [7:0] BYTE_LSB  = 8'h01;
    localparam int         PAGE_BITS = 8;

endpackage

`default_nettype wire

// File: sv/fbrf_mem.sv
// Page byte store: one write port, one read port with registered read data.
// No dependencies.
`default_nettype none

module fbrf_mem #(
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: sv/fbrf_seq.sv
// Sequencer and shared read-modify-write merge unit of the frame buffer.
// Walks the store for fills and rectangles; uses fbrf_pkg.
`default_nettype none

module fbrf_seq #(
    parameter int COLUMNS = 128,
    parameter int PAGES = 8,
    localparam int DEPTH = COLUMNS * PAGES,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [1:0]     i_operation,
    input  logic [7:0]     i_col_a,
    input  logic [7:0]     i_row_a,
    input  logic [7:0]     i_col_b,
    input  logic [7:0]     i_row_b,
    input  logic [7:0]     i_pattern,
    input  logic           i_pixel_on,
    input  logic           i_out_free,
    output fbrf_pkg::t_res o_res,
    output logic           o_we,
    output logic [AW-1:0]  o_waddr,
    output logic [7:0]     o_wdata,
    output logic           o_re,
    output logic [AW-1:0]  o_raddr,
    input  logic [7:0]     i_rdata
);

    import fbrf_pkg::*;

    localparam int ROWS = PAGE_BITS * PAGES;
    localparam int PW = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam logic [7:0]    COL_LIM   = 8'(COLUMNS);
    localparam logic [7:0]    ROW_LIM   = 8'(ROWS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    function automatic logic [AW-1:0] f_addr(input logic [PW-1:0] pg, input logic [7:0] col);
        f_addr = AW'(int'(pg) * COLUMNS + int'(col));
    endfunction

    function automatic logic [3:0] f_clamp(input logic [7:0] v, input logic [7:0] base);
        logic [7:0] d;
        d = v - base;
        if (v <= base) begin
            f_clamp = 4'd0;
        end else if (d >= 8'd8) begin
            f_clamp = 4'd8;
        end else begin
            f_clamp = d[3:0];
        end
    endfunction

    function automatic logic [7:0] f_mask(input logic [7:0] lo, input logic [7:0] hi,
                                          input logic [PW-1:0] pg);
        logic [7:0] base;
        logic [8:0] below_hi;
        logic [8:0] below_lo;
        base     = 8'({pg, 3'b000});
        below_hi = (9'd1 << f_clamp(hi, base)) - 9'd1;
        below_lo = (9'd1 << f_clamp(lo, base)) - 9'd1;
        f_mask   = below_hi[7:0] & ~below_lo[7:0] & BYTE_ALL;
    endfunction

    t_state        r_state, n_state;
    logic [AW-1:0] r_fill_addr, n_fill_addr;
    logic          r_wr_pend, n_wr_pend;
    logic [AW-1:0] r_wr_addr, n_wr_addr;
    logic [7:0]    r_mask, n_mask;
    logic [7:0]    r_pat, n_pat;
    logic [7:0]    r_col, n_col;
    logic [PW-1:0] r_page, n_page;
    logic [PW-1:0] r_last_page, n_last_page;
    logic [7:0]    r_x_lo, n_x_lo;
    logic [7:0]    r_x_hi, n_x_hi;
    logic [7:0]    r_y_lo, n_y_lo;
    logic [7:0]    r_y_hi, n_y_hi;
    logic          r_inside, n_inside;

    t_op           op;
    logic          in_range;
    logic [AW-1:0] pix_addr;
    logic [AW-1:0] rect_addr;
    logic [7:0]    x_lo, x_max, x_hi;
    logic [7:0]    y_lo, y_max, y_hi, y_last;
    logic          empty;

    assign op        = t_op'(i_operation);
    assign in_range  = (i_col_a < COL_LIM) && (i_row_a < ROW_LIM);
    assign pix_addr  = f_addr(PW'(i_row_a[7:3]), i_col_a);
    assign rect_addr = f_addr(r_page, r_col);

    assign x_lo   = (i_col_a <= i_col_b) ? i_col_a : i_col_b;
    assign x_max  = (i_col_a <= i_col_b) ? i_col_b : i_col_a;
    assign x_hi   = (x_max > COL_LIM) ? COL_LIM : x_max;
    assign y_lo   = (i_row_a <= i_row_b) ? i_row_a : i_row_b;
    assign y_max  = (i_row_a <= i_row_b) ? i_row_b : i_row_a;
    assign y_hi   = (y_max > ROW_LIM) ? ROW_LIM : y_max;
    assign y_last = y_hi - BYTE_LSB;
    assign empty  = (x_lo >= x_hi) || (y_lo >= y_hi);

    assign o_in_ready = (r_state == S_IDLE);
    assign o_we       = r_wr_pend;
    assign o_waddr    = r_wr_addr;
    assign o_wdata    = (i_rdata & ~r_mask) | (r_pat & r_mask);

    always_comb begin
        n_state     = r_state;
        n_fill_addr = r_fill_addr;
        n_wr_pend   = 1'b0;
        n_wr_addr   = r_wr_addr;
        n_mask      = r_mask;
        n_pat       = r_pat;
        n_col       = r_col;
        n_page      = r_page;
        n_last_page = r_last_page;
        n_x_lo      = r_x_lo;
        n_x_hi      = r_x_hi;
        n_y_lo      = r_y_lo;
        n_y_hi      = r_y_hi;
        n_inside    = r_inside;
        o_re        = 1'b0;
        o_raddr     = pix_addr;
        o_res       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (op)
                        OP_SET: begin
                            o_re      = 1'b1;
                            n_wr_pend = in_range;
                            n_wr_addr = pix_addr;
                            n_mask    = BYTE_LSB << i_row_a[2:0];
                            n_pat     = {8{i_pixel_on}};
                            n_state   = S_DRAIN;
                        end
                        OP_READ: begin
                            o_re     = 1'b1;
                            n_inside = in_range;
                            n_state  = S_RES;
                        end
                        OP_RECT: begin
                            n_pat       = i_pattern;
                            n_x_lo      = x_lo;
                            n_x_hi      = x_hi;
                            n_y_lo      = y_lo;
                            n_y_hi      = y_hi;
                            n_col       = x_lo;
                            n_page      = PW'(y_lo[7:3]);
                            n_last_page = PW'(y_last[7:3]);
                            n_state     = empty ? S_DRAIN : S_RECT;
                        end
                        OP_FILL: begin
                            n_pat       = i_pattern;
                            n_mask      = BYTE_ALL;
                            n_fill_addr = '0;
                            n_state     = S_FILL;
                        end
                        default: begin
                            n_state = S_DRAIN;
                        end
                    endcase
                end
            end
            S_FILL: begin
                n_wr_pend   = 1'b1;
                n_wr_addr   = r_fill_addr;
                n_mask      = BYTE_ALL;
                n_fill_addr = r_fill_addr + 1'b1;
                if (r_fill_addr == LAST_ADDR) begin
                    n_state = S_DRAIN;
                end
            end
            S_RECT: begin
                o_re      = 1'b1;
                o_raddr   = rect_addr;
                n_wr_pend = 1'b1;
                n_wr_addr = rect_addr;
                n_mask    = f_mask(r_y_lo, r_y_hi, r_page);
                if ((r_col + BYTE_LSB) == r_x_hi) begin
                    n_col = r_x_lo;
                    if (r_page == r_last_page) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_page = r_page + 1'b1;
                    end
                end else begin
                    n_col = r_col + BYTE_LSB;
                end
            end
            S_DRAIN: begin
                n_state = S_IDLE;
            end
            S_RES: begin
                if (i_out_free) begin
                    o_res.load = 1'b1;
                    o_res.zero = !r_inside;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // reset starts a zero fill of the whole store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_fill_addr <= '0;
            r_wr_pend   <= 1'b0;
            r_mask      <= BYTE_ALL;
            r_pat       <= '0;
        end else begin
            r_state     <= n_state;
            r_fill_addr <= n_fill_addr;
            r_wr_pend   <= n_wr_pend;
            r_mask      <= n_mask;
            r_pat       <= n_pat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr   <= n_wr_addr;
        r_col       <= n_col;
        r_page      <= n_page;
        r_last_page <= n_last_page;
        r_x_lo      <= n_x_lo;
        r_x_hi      <= n_x_hi;
        r_y_lo      <= n_y_lo;
        r_y_hi      <= n_y_hi;
        r_inside    <= n_inside;
    end

endmodule

`default_nettype wire

// File: sv/page_framebuffer_rect_fill_core.sv
// Monochrome page frame buffer: COLUMNS x PAGES bytes, bit b of page p is row 8*p+b.
// Set pixel is one read-modify-write of the store and read byte is one read of it;
// a rectangle fill merges one byte per cycle for each column and page touched
// through the single store port pair; fill all writes every byte of the store.
// After reset the store is zeroed by a pass over every byte, during
// which no transaction is taken. A read result sits in an output register; a
// read waits in the sequencer if the previous result has not been taken yet.
// Uses fbrf_pkg, fbrf_seq and fbrf_mem.
`default_nettype none

module page_framebuffer_rect_fill_core #(
    parameter int COLUMNS = 128,
    parameter int PAGES = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_operation,
    input  logic [7:0] i_col_a,
    input  logic [7:0] i_row_a,
    input  logic [7:0] i_col_b,
    input  logic [7:0] i_row_b,
    input  logic [7:0] i_pattern,
    input  logic       i_pixel_on,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_read_byte
);

    import fbrf_pkg::*;

    localparam int DEPTH = COLUMNS * PAGES;
    localparam int AW = $clog2(DEPTH);

    t_res          res;
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic          re;
    logic [AW-1:0] raddr;
    logic [7:0]    rdata;
    logic          out_free;
    logic          r_out_valid;
    logic [7:0]    r_read_byte;

    assign out_free = !r_out_valid || i_out_ready;

    fbrf_seq #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_col_a     (i_col_a),
        .i_row_a     (i_row_a),
        .i_col_b     (i_col_b),
        .i_row_b     (i_row_b),
        .i_pattern   (i_pattern),
        .i_pixel_on  (i_pixel_on),
        .i_out_free  (out_free),
        .o_res       (res),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_re        (re),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    fbrf_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.load) begin
            r_read_byte <= res.zero ? '0 : rdata;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_byte = r_read_byte;

endmodule

`default_nettype wire

// File: sv/fbrf_chk.sv
// Port-level checker for page_framebuffer_rect_fill_core, bound to the top level.
// Uses fbrf_pkg for the operation codes.
`default_nettype none

module fbrf_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [1:0] i_operation,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_read_byte
);

    import fbrf_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && o_in_ready;

    a_clear_busy: assert property (@(posedge i_clk) !i_rst_n |=> !o_in_ready && !o_out_valid)
        else $error("block ready or result valid right after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("transaction accepted while previous one in progress");

    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_operation == OP_READ) && !o_out_valid) |=> ##1 o_out_valid)
        else $error("read result not presented two cycles after accept");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_read_byte)))
        else $error("stalled result changed or dropped");

endmodule

bind page_framebuffer_rect_fill_core fbrf_chk u_fbrf_chk (.*);

`default_nettype wire
